### hdl/pmfp_pkg.sv
`default_nettype none

package pmfp_pkg;

    localparam int MAX_ROWS        = 8;
    localparam int MAX_INNER       = 8;
    localparam int MAX_COLS        = 8;
    localparam int MAX_MESH        = 64;
    localparam int MAX_ORDER       = 4;
    localparam int NODE_SLICES     = MAX_MESH + 1;
    localparam int CORR_SLICES     = MAX_ORDER * MAX_MESH;
    localparam int RES_CORR_SLICES = 2 * MAX_ORDER * MAX_MESH;
    localparam int NODE_DEPTH      = NODE_SLICES * 64;
    localparam int CORR_DEPTH      = CORR_SLICES * 64;
    localparam int RCORR_DEPTH     = RES_CORR_SLICES * 64;

    typedef enum logic [2:0] {
        CMD_LOAD_LEFT_NODE  = 3'd0,
        CMD_LOAD_LEFT_CORR  = 3'd1,
        CMD_LOAD_RIGHT_NODE = 3'd2,
        CMD_LOAD_RIGHT_CORR = 3'd3,
        CMD_COMPUTE         = 3'd4,
        CMD_READ_NODE       = 3'd5,
        CMD_READ_CORR       = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        OP_LOAD_LN,
        OP_LOAD_LC,
        OP_LOAD_RN,
        OP_LOAD_RC,
        OP_COMPUTE,
        OP_READ_NODE,
        OP_READ_CORR
    } t_op;

    typedef enum logic [2:0] {
        REG_ROW_COUNT    = 3'd0,
        REG_INNER_COUNT  = 3'd1,
        REG_COLUMN_COUNT = 3'd2,
        REG_MESH         = 3'd3,
        REG_LEFT_ORDER   = 3'd4,
        REG_RIGHT_ORDER  = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CLEAR,
        B_ISSUE,
        B_WAIT,
        B_FIN,
        B_RDADDR,
        B_RDOUT
    } t_bstate;

    // product terms: T_NODE for the node pass, the rest in the order they first occur in one interval
    typedef enum logic [2:0] {
        T_NODE,
        T_DD_NEG,
        T_DD_POS,
        T_NC,
        T_DC,
        T_CN,
        T_CD,
        T_CC
    } t_term;

    typedef enum logic [1:0] {
        SRC_NODE,
        SRC_DIFF,
        SRC_CORR
    } t_src;

    typedef struct packed {
        t_op                op;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [8:0]         slice;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [3:0] nr;
        logic [3:0] ni;
        logic [3:0] nc;
        logic [6:0] p;
        logic [2:0] r1;
        logic [2:0] r2;
    } t_cfg;

    function automatic logic [3:0] clamp_dim(input logic [3:0] v, input logic [3:0] hi);
        if (v == 4'd0) begin
            return 4'd1;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [6:0] clamp_mesh(input logic [6:0] v);
        if (v == 7'd0) begin
            return 7'd1;
        end else if (v > 7'(MAX_MESH)) begin
            return 7'(MAX_MESH);
        end
        return v;
    endfunction

    function automatic logic [2:0] clamp_order(input logic [2:0] v);
        if (v > 3'(MAX_ORDER)) begin
            return 3'(MAX_ORDER);
        end
        return v;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // hi - lo, saturated to 32 bits
    function automatic logic signed [31:0] sat_diff32(input logic signed [31:0] lo,
                                                      input logic signed [31:0] hi);
        logic signed [32:0] d;
        d = {hi[31], hi} - {lo[31], lo};
        if (d[32] != d[31]) begin
            return d[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return d[31:0];
    endfunction

    // Q32.32 -> Q16.16, floor and saturate
    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        if ((v[63:47] != {17{1'b0}}) && (v[63:47] != {17{1'b1}})) begin
            return v[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return v[47:16];
    endfunction

endpackage

`default_nettype wire

### hdl/pmfp_in_if.sv
`default_nettype none

interface pmfp_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic [8:0]         slice_index;
    logic signed [31:0] value;

    modport source (output valid, output command, output row_index, output col_index,
                    output slice_index, output value, input ready);
    modport sink   (input valid, input command, input row_index, input col_index,
                    input slice_index, input value, output ready);
endinterface

`default_nettype wire

### hdl/pmfp_out_if.sv
`default_nettype none

interface pmfp_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value_res;

    modport source (output valid, output kind, output value_res, input ready);
    modport sink   (input valid, input kind, input value_res, output ready);
endinterface

`default_nettype wire

### hdl/piecewise_matrix_function_product.sv
// Piecewise matrix function product, signed Q16.16 operands and results, Q32.32 sums.
// Commands enter on i_cmd and pass a 2-deep queue; loads are written from the queue
// head (out-of-range loads and command 7 are dropped at the input), reads return one
// element on o_res after they leave the queue. A compute command first runs a clearing
// pass over the result stores, then walks the loop nest one result element at a time;
// each element streams its inner-index products through a 4-stage multiply-accumulate
// pipeline. Node products take (p+1)*rows*cols elements; each mesh interval adds
// (2 + 2*r2 + r1*(2 + r2)) product terms of rows*cols elements. One transfer with kind 0
// marks the end. Reads before the first compute return 0. Configuration is written over
// the APB port, by the user only while the block is idle; the block does not enforce it.
`default_nettype none

module piecewise_matrix_function_product (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pmfp_in_if.sink          i_cmd,
    pmfp_out_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // configuration registers, raw as written
    logic [3:0] r_row_count;
    logic [3:0] r_inner_count;
    logic [3:0] r_column_count;
    logic [6:0] r_mesh;
    logic [2:0] r_left_order;
    logic [2:0] r_right_order;

    logic                 wr;
    pmfp_pkg::t_cfg       cfg;
    logic                 q_valid;
    logic                 q_pop;
    pmfp_pkg::t_item      q_item;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= 4'd8;
            r_inner_count  <= 4'd8;
            r_column_count <= 4'd8;
            r_mesh         <= 7'd64;
            r_left_order   <= 3'd0;
            r_right_order  <= 3'd0;
        end else if (wr) begin
            unique case (paddr[4:2])
                pmfp_pkg::REG_ROW_COUNT:    r_row_count    <= pwdata[3:0];
                pmfp_pkg::REG_INNER_COUNT:  r_inner_count  <= pwdata[3:0];
                pmfp_pkg::REG_COLUMN_COUNT: r_column_count <= pwdata[3:0];
                pmfp_pkg::REG_MESH:         r_mesh         <= pwdata[6:0];
                pmfp_pkg::REG_LEFT_ORDER:   r_left_order   <= pwdata[2:0];
                pmfp_pkg::REG_RIGHT_ORDER:  r_right_order  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pmfp_pkg::REG_ROW_COUNT:    prdata = {28'd0, r_row_count};
            pmfp_pkg::REG_INNER_COUNT:  prdata = {28'd0, r_inner_count};
            pmfp_pkg::REG_COLUMN_COUNT: prdata = {28'd0, r_column_count};
            pmfp_pkg::REG_MESH:         prdata = {25'd0, r_mesh};
            pmfp_pkg::REG_LEFT_ORDER:   prdata = {29'd0, r_left_order};
            pmfp_pkg::REG_RIGHT_ORDER:  prdata = {29'd0, r_right_order};
            default:                    prdata = '0;
        endcase
    end

    // effective sizes: dimensions 1..8, mesh 1..64, orders 0..4
    assign cfg.nr = pmfp_pkg::clamp_dim(r_row_count, 4'(pmfp_pkg::MAX_ROWS));
    assign cfg.ni = pmfp_pkg::clamp_dim(r_inner_count, 4'(pmfp_pkg::MAX_INNER));
    assign cfg.nc = pmfp_pkg::clamp_dim(r_column_count, 4'(pmfp_pkg::MAX_COLS));
    assign cfg.p  = pmfp_pkg::clamp_mesh(r_mesh);
    assign cfg.r1 = pmfp_pkg::clamp_order(r_left_order);
    assign cfg.r2 = pmfp_pkg::clamp_order(r_right_order);

    // front: decode and queue
    pmfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // back: stores, product pipeline, result transfer register
    pmfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

### hdl/pmfp_front.sv
`default_nettype none

// Decodes commands, drops the ones with no effect, queues the rest (2 deep).
module pmfp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    pmfp_in_if.sink              i_cmd,
    output logic                 o_q_valid,
    output pmfp_pkg::t_item      o_q_item,
    input  wire logic            i_q_pop
);

    pmfp_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    pmfp_pkg::t_item n_item;
    logic            keep;
    logic            push;

    always_comb begin
        keep         = 1'b1;
        n_item.op    = pmfp_pkg::OP_COMPUTE;
        n_item.row   = i_cmd.row_index;
        n_item.col   = i_cmd.col_index;
        n_item.slice = i_cmd.slice_index;
        n_item.value = i_cmd.value;
        unique case (i_cmd.command)
            pmfp_pkg::CMD_LOAD_LEFT_NODE: begin
                n_item.op = pmfp_pkg::OP_LOAD_LN;
                keep      = i_cmd.slice_index < 9'(pmfp_pkg::NODE_SLICES);
            end
            pmfp_pkg::CMD_LOAD_LEFT_CORR: begin
                n_item.op = pmfp_pkg::OP_LOAD_LC;
                keep      = i_cmd.slice_index < 9'(pmfp_pkg::CORR_SLICES);
            end
            pmfp_pkg::CMD_LOAD_RIGHT_NODE: begin
                n_item.op = pmfp_pkg::OP_LOAD_RN;
                keep      = i_cmd.slice_index < 9'(pmfp_pkg::NODE_SLICES);
            end
            pmfp_pkg::CMD_LOAD_RIGHT_CORR: begin
                n_item.op = pmfp_pkg::OP_LOAD_RC;
                keep      = i_cmd.slice_index < 9'(pmfp_pkg::CORR_SLICES);
            end
            pmfp_pkg::CMD_COMPUTE:   n_item.op = pmfp_pkg::OP_COMPUTE;
            pmfp_pkg::CMD_READ_NODE: n_item.op = pmfp_pkg::OP_READ_NODE;
            pmfp_pkg::CMD_READ_CORR: n_item.op = pmfp_pkg::OP_READ_CORR;
            default:                 keep = 1'b0;
        endcase
    end

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready && keep;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

`default_nettype wire

### hdl/pmfp_back.sv
`default_nettype none

// Executes queued commands: operand stores, product pipeline, result stores.
module pmfp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  pmfp_pkg::t_cfg       i_cfg,
    input  wire logic            i_q_valid,
    input  pmfp_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    pmfp_out_if.source           o_res
);

    localparam int NAW = $clog2(pmfp_pkg::NODE_DEPTH);
    localparam int CAW = $clog2(pmfp_pkg::CORR_DEPTH);
    localparam int RAW = $clog2(pmfp_pkg::RCORR_DEPTH);

    // stores
    logic        [31:0] r_ln_mem [pmfp_pkg::NODE_DEPTH];
    logic        [31:0] r_lc_mem [pmfp_pkg::CORR_DEPTH];
    logic        [31:0] r_rn_mem [pmfp_pkg::NODE_DEPTH];
    logic        [31:0] r_rc_mem [pmfp_pkg::CORR_DEPTH];
    logic        [31:0] r_res_node_mem [pmfp_pkg::NODE_DEPTH];
    logic        [63:0] r_res_acc_mem [pmfp_pkg::RCORR_DEPTH];

    pmfp_pkg::t_bstate r_state, n_state;
    pmfp_pkg::t_term   r_term, n_term;
    logic [6:0]        r_j, n_j;
    logic [2:0]        r_i, n_i, r_c, n_c, r_k, n_k, r_l, n_l, r_ko, n_ko;
    logic [RAW-1:0]    r_clr, n_clr;
    logic              r_have, n_have;
    pmfp_pkg::t_item   r_cur, n_cur;
    logic              r_out_valid, n_out_valid;
    logic              r_kind, n_kind;
    logic signed [31:0] r_val, n_val;

    // pipeline
    logic               r_v1, r_f1, r_l1, r_v2, r_f2, r_l2, r_v3, r_f3, r_l3, r_v4, r_l4;
    logic signed [31:0] r_ln_a_q, r_ln_b_q, r_lc_q, r_rn_a_q, r_rn_b_q, r_rc_q;
    logic signed [31:0] r_a, r_b;
    logic signed [63:0] r_prod, r_sum;
    logic signed [31:0] r_res_node_q;
    logic signed [63:0] r_acc_q;

    // term descriptor
    logic [3:0]       dst_m;
    logic [8:0]       dst_slice;
    logic [8:0]       lc_full, rc_full;
    logic [6:0]       j_next;
    pmfp_pkg::t_src   lsrc, rsrc;
    logic             neg;
    logic             issue, first0, last0, fin, out_free, clearing;
    logic signed [31:0] opa, opb;
    logic signed [63:0] acc_new;

    logic [NAW-1:0] ln_a_addr, ln_b_addr, rn_a_addr, rn_b_addr, ld_node_addr, rn_rd_addr;
    logic [NAW-1:0] res_node_waddr;
    logic [CAW-1:0] lc_addr, rc_addr, ld_corr_addr;
    logic [RAW-1:0] acc_raddr, acc_waddr, elem_addr;
    logic           res_node_we, acc_we;
    logic           we_ln, we_lc, we_rn, we_rc;
    logic signed [31:0] res_node_wdata;
    logic signed [63:0] acc_wdata;
    logic           adv_j;

    always_comb begin
        lsrc  = pmfp_pkg::SRC_NODE;
        rsrc  = pmfp_pkg::SRC_NODE;
        neg   = 1'b0;
        dst_m = 4'd0;
        unique case (r_term)
            pmfp_pkg::T_NODE: ;
            pmfp_pkg::T_DD_NEG: begin
                lsrc = pmfp_pkg::SRC_DIFF;
                rsrc = pmfp_pkg::SRC_DIFF;
                neg  = 1'b1;
            end
            pmfp_pkg::T_DD_POS: begin
                lsrc  = pmfp_pkg::SRC_DIFF;
                rsrc  = pmfp_pkg::SRC_DIFF;
                dst_m = 4'd1;
            end
            pmfp_pkg::T_NC: begin
                rsrc  = pmfp_pkg::SRC_CORR;
                dst_m = {1'b0, r_l};
            end
            pmfp_pkg::T_DC: begin
                lsrc  = pmfp_pkg::SRC_DIFF;
                rsrc  = pmfp_pkg::SRC_CORR;
                dst_m = {1'b0, r_l} + 4'd1;
            end
            pmfp_pkg::T_CN: begin
                lsrc  = pmfp_pkg::SRC_CORR;
                dst_m = {1'b0, r_ko};
            end
            pmfp_pkg::T_CD: begin
                lsrc  = pmfp_pkg::SRC_CORR;
                rsrc  = pmfp_pkg::SRC_DIFF;
                dst_m = {1'b0, r_ko} + 4'd1;
            end
            pmfp_pkg::T_CC: begin
                lsrc  = pmfp_pkg::SRC_CORR;
                rsrc  = pmfp_pkg::SRC_CORR;
                dst_m = {1'b0, r_ko} + {1'b0, r_l} + 4'd1;
            end
            default: ;
        endcase
    end

    assign dst_slice = 9'(r_j) + 9'(dst_m) * 9'(i_cfg.p);
    assign lc_full   = 9'(r_j) + 9'(r_ko) * 9'(i_cfg.p);
    assign rc_full   = 9'(r_j) + 9'(r_l) * 9'(i_cfg.p);
    assign j_next    = r_j + 7'd1;

    assign ln_a_addr = {r_j, r_i, r_k};
    assign ln_b_addr = {j_next, r_i, r_k};
    assign lc_addr   = {lc_full[7:0], r_i, r_k};
    assign rn_a_addr = {r_j, r_k, r_c};
    assign rn_b_addr = {j_next, r_k, r_c};
    assign rc_addr   = {rc_full[7:0], r_k, r_c};
    assign elem_addr = {dst_slice, r_i, r_c};

    assign issue    = (r_state == pmfp_pkg::B_ISSUE);
    assign first0   = (r_k == 3'd0);
    assign last0    = ({1'b0, r_k} == i_cfg.ni - 4'd1);
    assign fin      = r_v4 && r_l4;
    assign out_free = !r_out_valid || o_res.ready;
    assign clearing = (r_state == pmfp_pkg::B_CLEAR);

    // loads go straight from the queue head
    assign ld_node_addr = {i_q_item.slice[6:0], i_q_item.row, i_q_item.col};
    assign ld_corr_addr = {i_q_item.slice[7:0], i_q_item.row, i_q_item.col};
    assign we_ln = o_q_pop && (i_q_item.op == pmfp_pkg::OP_LOAD_LN);
    assign we_lc = o_q_pop && (i_q_item.op == pmfp_pkg::OP_LOAD_LC);
    assign we_rn = o_q_pop && (i_q_item.op == pmfp_pkg::OP_LOAD_RN);
    assign we_rc = o_q_pop && (i_q_item.op == pmfp_pkg::OP_LOAD_RC);

    always_ff @(posedge i_clk) begin
        if (we_ln) begin
            r_ln_mem[ld_node_addr] <= i_q_item.value;
        end
        r_ln_a_q <= r_ln_mem[ln_a_addr];
        r_ln_b_q <= r_ln_mem[ln_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_lc) begin
            r_lc_mem[ld_corr_addr] <= i_q_item.value;
        end
        r_lc_q <= r_lc_mem[lc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_rn) begin
            r_rn_mem[ld_node_addr] <= i_q_item.value;
        end
        r_rn_a_q <= r_rn_mem[rn_a_addr];
        r_rn_b_q <= r_rn_mem[rn_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_rc) begin
            r_rc_mem[ld_corr_addr] <= i_q_item.value;
        end
        r_rc_q <= r_rc_mem[rc_addr];
    end

    // result stores: cleared by the sweep, written at element finish
    assign acc_new = neg ? pmfp_pkg::sat_sub64(r_acc_q, r_sum)
                         : pmfp_pkg::sat_add64(r_acc_q, r_sum);

    always_comb begin
        res_node_we    = 1'b0;
        res_node_waddr = {r_j, r_i, r_c};
        res_node_wdata = pmfp_pkg::to_q16(r_sum);
        acc_we         = 1'b0;
        acc_waddr      = elem_addr;
        acc_wdata      = acc_new;
        if (clearing) begin
            res_node_we    = (r_clr < RAW'(pmfp_pkg::NODE_DEPTH));
            res_node_waddr = r_clr[NAW-1:0];
            res_node_wdata = '0;
            acc_we         = 1'b1;
            acc_waddr      = r_clr;
            acc_wdata      = '0;
        end else if ((r_state == pmfp_pkg::B_WAIT) && fin) begin
            res_node_we = (r_term == pmfp_pkg::T_NODE);
            acc_we      = (r_term != pmfp_pkg::T_NODE);
        end
    end

    assign rn_rd_addr = {r_cur.slice[6:0], r_cur.row, r_cur.col};
    assign acc_raddr  = ((r_state == pmfp_pkg::B_RDADDR) || (r_state == pmfp_pkg::B_RDOUT))
                        ? {r_cur.slice, r_cur.row, r_cur.col} : elem_addr;

    always_ff @(posedge i_clk) begin
        if (res_node_we) begin
            r_res_node_mem[res_node_waddr] <= res_node_wdata;
        end
        r_res_node_q <= r_res_node_mem[rn_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_res_acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_q <= r_res_acc_mem[acc_raddr];
    end

    // operand select, multiply, accumulate over the inner index
    always_comb begin
        case (lsrc)
            pmfp_pkg::SRC_DIFF: opa = pmfp_pkg::sat_diff32(r_ln_a_q, r_ln_b_q);
            pmfp_pkg::SRC_CORR: opa = r_lc_q;
            default:            opa = r_ln_a_q;
        endcase
        case (rsrc)
            pmfp_pkg::SRC_DIFF: opb = pmfp_pkg::sat_diff32(r_rn_a_q, r_rn_b_q);
            pmfp_pkg::SRC_CORR: opb = r_rc_q;
            default:            opb = r_rn_a_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a    <= opa;
        r_b    <= opb;
        r_prod <= r_a * r_b;
        if (r_v3) begin
            r_sum <= pmfp_pkg::sat_add64(r_f3 ? 64'sd0 : r_sum, r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_f1 <= 1'b0;
            r_f2 <= 1'b0;
            r_f3 <= 1'b0;
            r_l1 <= 1'b0;
            r_l2 <= 1'b0;
            r_l3 <= 1'b0;
            r_l4 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_f1 <= first0;
            r_l1 <= issue && last0;
            r_v2 <= r_v1;
            r_f2 <= r_f1;
            r_l2 <= r_l1;
            r_v3 <= r_v2;
            r_f3 <= r_f2;
            r_l3 <= r_l2;
            r_v4 <= r_v3;
            r_l4 <= r_l3;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_j         = r_j;
        n_i         = r_i;
        n_c         = r_c;
        n_k         = r_k;
        n_l         = r_l;
        n_ko        = r_ko;
        n_clr       = r_clr;
        n_have      = r_have;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_val       = r_val;
        o_q_pop     = 1'b0;
        adv_j       = 1'b0;
        unique case (r_state)
            pmfp_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_item;
                    unique case (i_q_item.op) inside
                        pmfp_pkg::OP_COMPUTE: begin
                            n_state = pmfp_pkg::B_CLEAR;
                            n_clr   = '0;
                        end
                        pmfp_pkg::OP_READ_NODE, pmfp_pkg::OP_READ_CORR: begin
                            n_state = pmfp_pkg::B_RDADDR;
                        end
                        default: ;
                    endcase
                end
            end
            pmfp_pkg::B_CLEAR: begin
                n_clr = r_clr + RAW'(1);
                if (r_clr == RAW'(pmfp_pkg::RCORR_DEPTH - 1)) begin
                    n_state = pmfp_pkg::B_ISSUE;
                    n_term  = pmfp_pkg::T_NODE;
                    n_j     = '0;
                    n_i     = '0;
                    n_c     = '0;
                    n_k     = '0;
                end
            end
            pmfp_pkg::B_ISSUE: begin
                n_k = r_k + 3'd1;
                if (last0) begin
                    n_k     = '0;
                    n_state = pmfp_pkg::B_WAIT;
                end
            end
            pmfp_pkg::B_WAIT: begin
                if (fin) begin
                    n_state = pmfp_pkg::B_ISSUE;
                    if ({1'b0, r_c} != i_cfg.nc - 4'd1) begin
                        n_c = r_c + 3'd1;
                    end else begin
                        n_c = '0;
                        if ({1'b0, r_i} != i_cfg.nr - 4'd1) begin
                            n_i = r_i + 3'd1;
                        end else begin
                            n_i = '0;
                            unique case (r_term)
                                pmfp_pkg::T_NODE: begin
                                    if (r_j == i_cfg.p) begin
                                        n_term = pmfp_pkg::T_DD_NEG;
                                        n_j    = '0;
                                    end else begin
                                        n_j = j_next;
                                    end
                                end
                                pmfp_pkg::T_DD_NEG: n_term = pmfp_pkg::T_DD_POS;
                                pmfp_pkg::T_DD_POS: begin
                                    if (i_cfg.r2 != 3'd0) begin
                                        n_term = pmfp_pkg::T_NC;
                                        n_l    = '0;
                                    end else if (i_cfg.r1 != 3'd0) begin
                                        n_term = pmfp_pkg::T_CN;
                                        n_ko   = '0;
                                    end else begin
                                        adv_j = 1'b1;
                                    end
                                end
                                pmfp_pkg::T_NC: n_term = pmfp_pkg::T_DC;
                                pmfp_pkg::T_DC: begin
                                    if (r_l + 3'd1 < i_cfg.r2) begin
                                        n_term = pmfp_pkg::T_NC;
                                        n_l    = r_l + 3'd1;
                                    end else if (i_cfg.r1 != 3'd0) begin
                                        n_term = pmfp_pkg::T_CN;
                                        n_ko   = '0;
                                    end else begin
                                        adv_j = 1'b1;
                                    end
                                end
                                pmfp_pkg::T_CN: n_term = pmfp_pkg::T_CD;
                                pmfp_pkg::T_CD: begin
                                    if (i_cfg.r2 != 3'd0) begin
                                        n_term = pmfp_pkg::T_CC;
                                        n_l    = '0;
                                    end else if (r_ko + 3'd1 < i_cfg.r1) begin
                                        n_term = pmfp_pkg::T_CN;
                                        n_ko   = r_ko + 3'd1;
                                    end else begin
                                        adv_j = 1'b1;
                                    end
                                end
                                default: begin
                                    // cross term
                                    if (r_l + 3'd1 < i_cfg.r2) begin
                                        n_l = r_l + 3'd1;
                                    end else if (r_ko + 3'd1 < i_cfg.r1) begin
                                        n_term = pmfp_pkg::T_CN;
                                        n_ko   = r_ko + 3'd1;
                                    end else begin
                                        adv_j = 1'b1;
                                    end
                                end
                            endcase
                            if (adv_j) begin
                                if (j_next < i_cfg.p) begin
                                    n_j    = j_next;
                                    n_term = pmfp_pkg::T_DD_NEG;
                                end else begin
                                    n_state = pmfp_pkg::B_FIN;
                                end
                            end
                        end
                    end
                end
            end
            pmfp_pkg::B_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_val       = '0;
                    n_have      = 1'b1;
                    n_state     = pmfp_pkg::B_IDLE;
                end
            end
            pmfp_pkg::B_RDADDR: n_state = pmfp_pkg::B_RDOUT;
            pmfp_pkg::B_RDOUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_val       = '0;
                    if (r_have) begin
                        if (r_cur.op == pmfp_pkg::OP_READ_CORR) begin
                            n_val = pmfp_pkg::to_q16(r_acc_q);
                        end else if (r_cur.slice < 9'(pmfp_pkg::NODE_SLICES)) begin
                            n_val = r_res_node_q;
                        end
                    end
                    n_state = pmfp_pkg::B_IDLE;
                end
            end
            default: n_state = pmfp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmfp_pkg::B_IDLE;
            r_term      <= pmfp_pkg::T_NODE;
            r_j         <= '0;
            r_i         <= '0;
            r_c         <= '0;
            r_k         <= '0;
            r_l         <= '0;
            r_ko        <= '0;
            r_clr       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_j         <= n_j;
            r_i         <= n_i;
            r_c         <= n_c;
            r_k         <= n_k;
            r_l         <= n_l;
            r_ko        <= n_ko;
            r_clr       <= n_clr;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_kind <= n_kind;
        r_val  <= n_val;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_kind;
    assign o_res.value_res = r_val;

    a_fin_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_l4) |-> (r_state == pmfp_pkg::B_WAIT))
        else $error("element finished outside wait state");

    a_one_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_v1 && r_l1, r_v2 && r_l2, r_v3 && r_l3, r_v4 && r_l4}))
        else $error("more than one element in the product pipeline");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmfp_pkg::B_CLEAR) |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("product pipeline busy during clearing pass");

endmodule

`default_nettype wire

### verif/tb_piecewise_matrix_function_product.sv
`default_nettype none

module tb_piecewise_matrix_function_product;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    // one address past the last register, written once; no register sits there
    localparam logic [4:0] ADDR_NO_REG  = 5'd24;
    localparam int         STALL_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 40;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [8:0]  slice;
        logic [31:0] value;
    } t_cmd_item;

    typedef struct {
        logic        kind;
        logic [31:0] value;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pmfp_in_if  cmd_if ();
    pmfp_out_if res_if ();

    piecewise_matrix_function_product DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: operand stores, result stores, configuration.
    // ------------------------------------------------------------------
    int     lnode [pmfp_pkg::NODE_DEPTH];
    int     lcorr [pmfp_pkg::CORR_DEPTH];
    int     rnode [pmfp_pkg::NODE_DEPTH];
    int     rcorr [pmfp_pkg::CORR_DEPTH];
    int     res_node [pmfp_pkg::NODE_DEPTH];
    int     res_corr [pmfp_pkg::RCORR_DEPTH];
    longint corr_sum [pmfp_pkg::RCORR_DEPTH];

    // elements already queued for loading; a compute never reads anything else
    bit lnode_set [pmfp_pkg::NODE_DEPTH];
    bit lcorr_set [pmfp_pkg::CORR_DEPTH];
    bit rnode_set [pmfp_pkg::NODE_DEPTH];
    bit rcorr_set [pmfp_pkg::CORR_DEPTH];

    // raw register values and their clamped effect
    logic [3:0] reg_rows = 4'd8, reg_inner = 4'd8, reg_cols = 4'd8;
    logic [6:0] reg_mesh = 7'd64;
    logic [2:0] reg_lord = 3'd0, reg_rord = 3'd0;
    int nr_e, ni_e, nc_e, p_e, r1_e, r2_e;

    t_cmd_item cmd_backlog[$];
    t_result   awaited[$];

    bit calm = 1'b0;
    int errors = 0;
    int n_computes = 0, n_reads = 0, n_loads = 0, n_phases = 0;

    function automatic int clamp_to(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void refresh_sizes();
        nr_e = clamp_to(int'(reg_rows), 1, pmfp_pkg::MAX_ROWS);
        ni_e = clamp_to(int'(reg_inner), 1, pmfp_pkg::MAX_INNER);
        nc_e = clamp_to(int'(reg_cols), 1, pmfp_pkg::MAX_COLS);
        p_e  = clamp_to(int'(reg_mesh), 1, pmfp_pkg::MAX_MESH);
        r1_e = clamp_to(int'(reg_lord), 0, pmfp_pkg::MAX_ORDER);
        r2_e = clamp_to(int'(reg_rord), 0, pmfp_pkg::MAX_ORDER);
    endfunction

    function automatic longint sat_plus(longint a, longint b);
        longint r = a + b;
        if (a >= 0 && b > 0 && r < 0) return 64'sh7fffffffffffffff;
        if (a < 0 && b < 0 && r >= 0) return 64'sh8000000000000000;
        return r;
    endfunction

    function automatic longint sat_minus(longint a, longint b);
        longint r = a - b;
        if (a >= 0 && b < 0 && r < 0) return 64'sh7fffffffffffffff;
        if (a < 0 && b > 0 && r >= 0) return 64'sh8000000000000000;
        return r;
    endfunction

    // mesh difference hi - lo, saturated to Q16.16
    function automatic longint step_diff(int hi, int lo);
        longint d = longint'(hi) - longint'(lo);
        if (d > 64'sd2147483647) return 64'sd2147483647;
        if (d < -64'sd2147483648) return -64'sd2147483648;
        return d;
    endfunction

    // Q32.32 -> Q16.16, floor then saturate
    function automatic int narrow_q16(longint v);
        if (v > (64'sd1 <<< 47) - 1) return 32'sh7fffffff;
        if (v < -(64'sd1 <<< 47)) return 32'sh80000000;
        return int'(v >>> 16);
    endfunction

    function automatic longint left_term(pmfp_pkg::t_src src, int s, int i, int k);
        int at = (s * pmfp_pkg::MAX_ROWS + i) * pmfp_pkg::MAX_INNER + k;
        case (src)
            pmfp_pkg::SRC_CORR: return longint'(lcorr[at]);
            pmfp_pkg::SRC_DIFF:
                return step_diff(lnode[at + pmfp_pkg::MAX_ROWS * pmfp_pkg::MAX_INNER],
                                 lnode[at]);
            default:  return longint'(lnode[at]);
        endcase
    endfunction

    function automatic longint right_term(pmfp_pkg::t_src src, int s, int k, int c);
        int at = (s * pmfp_pkg::MAX_INNER + k) * pmfp_pkg::MAX_COLS + c;
        case (src)
            pmfp_pkg::SRC_CORR: return longint'(rcorr[at]);
            pmfp_pkg::SRC_DIFF:
                return step_diff(rnode[at + pmfp_pkg::MAX_INNER * pmfp_pkg::MAX_COLS],
                                 rnode[at]);
            default:  return longint'(rnode[at]);
        endcase
    endfunction

    function automatic longint dot_q32(pmfp_pkg::t_src ls, int lsl, pmfp_pkg::t_src rs,
                                       int rsl, int i, int c);
        longint acc = 0;
        for (int k = 0; k < ni_e; k++) begin
            acc = sat_plus(acc, left_term(ls, lsl, i, k) * right_term(rs, rsl, k, c));
        end
        return acc;
    endfunction

    function automatic void fold_term(int dst, pmfp_pkg::t_src ls, int lsl,
                                      pmfp_pkg::t_src rs, int rsl, bit neg);
        int at;
        longint t;
        for (int i = 0; i < nr_e; i++) begin
            for (int c = 0; c < nc_e; c++) begin
                at = (dst * pmfp_pkg::MAX_ROWS + i) * pmfp_pkg::MAX_COLS + c;
                t = dot_q32(ls, lsl, rs, rsl, i, c);
                corr_sum[at] = neg ? sat_minus(corr_sum[at], t) : sat_plus(corr_sum[at], t);
            end
        end
    endfunction

    function automatic void form_product();
        int p = p_e;
        foreach (res_node[n]) res_node[n] = 0;
        foreach (corr_sum[n]) corr_sum[n] = 0;
        for (int j = 0; j <= p; j++) begin
            for (int i = 0; i < nr_e; i++) begin
                for (int c = 0; c < nc_e; c++) begin
                    res_node[(j * pmfp_pkg::MAX_ROWS + i) * pmfp_pkg::MAX_COLS + c] =
                        narrow_q16(dot_q32(pmfp_pkg::SRC_NODE, j, pmfp_pkg::SRC_NODE, j,
                                           i, c));
                end
            end
        end
        for (int j = 0; j < p; j++) begin
            fold_term(j, pmfp_pkg::SRC_DIFF, j, pmfp_pkg::SRC_DIFF, j, 1'b1);
            fold_term(j + p, pmfp_pkg::SRC_DIFF, j, pmfp_pkg::SRC_DIFF, j, 1'b0);
            for (int l = 0; l < r2_e; l++) begin
                fold_term(j + l * p, pmfp_pkg::SRC_NODE, j, pmfp_pkg::SRC_CORR, j + l * p,
                          1'b0);
                fold_term(j + (l + 1) * p, pmfp_pkg::SRC_DIFF, j, pmfp_pkg::SRC_CORR,
                          j + l * p, 1'b0);
            end
            for (int k = 0; k < r1_e; k++) begin
                fold_term(j + k * p, pmfp_pkg::SRC_CORR, j + k * p, pmfp_pkg::SRC_NODE, j,
                          1'b0);
                fold_term(j + (k + 1) * p, pmfp_pkg::SRC_CORR, j + k * p,
                          pmfp_pkg::SRC_DIFF, j, 1'b0);
                for (int l = 0; l < r2_e; l++) begin
                    fold_term(j + (k + l + 1) * p, pmfp_pkg::SRC_CORR, j + k * p,
                              pmfp_pkg::SRC_CORR, j + l * p, 1'b0);
                end
            end
        end
        foreach (corr_sum[n]) res_corr[n] = narrow_q16(corr_sum[n]);
    endfunction

    // Apply one accepted command to the shadow and queue what it must return.
    function automatic void apply_command(t_cmd_item it);
        int lidx = (int'(it.slice) * pmfp_pkg::MAX_ROWS + int'(it.row)) * pmfp_pkg::MAX_INNER
                   + int'(it.col);
        int ridx = (int'(it.slice) * pmfp_pkg::MAX_INNER + int'(it.row)) * pmfp_pkg::MAX_COLS
                   + int'(it.col);
        int oidx = (int'(it.slice) * pmfp_pkg::MAX_ROWS + int'(it.row)) * pmfp_pkg::MAX_COLS
                   + int'(it.col);
        t_result r;
        case (it.cmd)
            pmfp_pkg::CMD_LOAD_LEFT_NODE:
                if (it.slice < pmfp_pkg::NODE_SLICES) lnode[lidx] = it.value;
            pmfp_pkg::CMD_LOAD_LEFT_CORR:
                if (it.slice < pmfp_pkg::CORR_SLICES) lcorr[lidx] = it.value;
            pmfp_pkg::CMD_LOAD_RIGHT_NODE:
                if (it.slice < pmfp_pkg::NODE_SLICES) rnode[ridx] = it.value;
            pmfp_pkg::CMD_LOAD_RIGHT_CORR:
                if (it.slice < pmfp_pkg::CORR_SLICES) rcorr[ridx] = it.value;
            pmfp_pkg::CMD_COMPUTE: begin
                form_product();
                r.kind = 1'b0;
                r.value = '0;
                awaited.push_back(r);
            end
            pmfp_pkg::CMD_READ_NODE: begin
                r.kind = 1'b1;
                r.value = (it.slice < pmfp_pkg::NODE_SLICES) ? res_node[oidx] : 0;
                awaited.push_back(r);
            end
            pmfp_pkg::CMD_READ_CORR: begin
                r.kind = 1'b1;
                r.value = (it.slice < pmfp_pkg::RES_CORR_SLICES) ? res_corr[oidx] : 0;
                awaited.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: pops the backlog, random gaps unless in a calm phase.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_cmd_item nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                nxt = cmd_backlog.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.command     <= nxt.cmd;
                cmd_if.row_index   <= nxt.row;
                cmd_if.col_index   <= nxt.col;
                cmd_if.slice_index <= nxt.slice;
                cmd_if.value       <= nxt.value;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        res_if.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 36);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each command transfer, check each result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_cmd_item seen;
        t_result   want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d value %h", $time,
                         res_if.kind, res_if.value_res);
            end else begin
                want = awaited.pop_front();
                if (res_if.kind !== want.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time,
                             want.kind, res_if.kind);
                end
                if (res_if.value_res !== want.value) begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time,
                             want.value, res_if.value_res);
                end
            end
        end
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            seen.cmd   = cmd_if.command;
            seen.row   = cmd_if.row_index;
            seen.col   = cmd_if.col_index;
            seen.slice = cmd_if.slice_index;
            seen.value = cmd_if.value;
            apply_command(seen);
        end
    end

    // Watchdog: any transfer (command, result or register write) restarts it.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
            || (psel && penable) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, awaited.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic void push_item(logic [2:0] cmd, int row, int col, int slice,
                                      logic [31:0] value);
        t_cmd_item it;
        int lidx = (slice * pmfp_pkg::MAX_ROWS + row) * pmfp_pkg::MAX_INNER + col;
        int ridx = (slice * pmfp_pkg::MAX_INNER + row) * pmfp_pkg::MAX_COLS + col;
        it.cmd = cmd;
        it.row = 3'(row);
        it.col = 3'(col);
        it.slice = 9'(slice);
        it.value = value;
        case (cmd)
            pmfp_pkg::CMD_LOAD_LEFT_NODE:
                if (slice < pmfp_pkg::NODE_SLICES) lnode_set[lidx] = 1'b1;
            pmfp_pkg::CMD_LOAD_LEFT_CORR:
                if (slice < pmfp_pkg::CORR_SLICES) lcorr_set[lidx] = 1'b1;
            pmfp_pkg::CMD_LOAD_RIGHT_NODE:
                if (slice < pmfp_pkg::NODE_SLICES) rnode_set[ridx] = 1'b1;
            pmfp_pkg::CMD_LOAD_RIGHT_CORR:
                if (slice < pmfp_pkg::CORR_SLICES) rcorr_set[ridx] = 1'b1;
            pmfp_pkg::CMD_COMPUTE: n_computes++;
            pmfp_pkg::CMD_READ_NODE, pmfp_pkg::CMD_READ_CORR: n_reads++;
            default: ;
        endcase
        if (cmd <= pmfp_pkg::CMD_LOAD_RIGHT_CORR) n_loads++;
        cmd_backlog.push_back(it);
    endfunction

    // load every operand element the next compute will touch and that was never loaded
    function automatic void fill_operands();
        int li;
        int ri;
        for (int s = 0; s <= p_e; s++)
            for (int a = 0; a < pmfp_pkg::MAX_ROWS; a++)
                for (int b = 0; b < pmfp_pkg::MAX_INNER; b++) begin
                    li = (s * pmfp_pkg::MAX_ROWS + a) * pmfp_pkg::MAX_INNER + b;
                    ri = (s * pmfp_pkg::MAX_INNER + a) * pmfp_pkg::MAX_COLS + b;
                    if (a < nr_e && b < ni_e && !lnode_set[li])
                        push_item(pmfp_pkg::CMD_LOAD_LEFT_NODE, a, b, s, pick_value());
                    if (a < ni_e && b < nc_e && !rnode_set[ri])
                        push_item(pmfp_pkg::CMD_LOAD_RIGHT_NODE, a, b, s, pick_value());
                end
        for (int s = 0; s < pmfp_pkg::MAX_ORDER * p_e; s++)
            for (int a = 0; a < pmfp_pkg::MAX_ROWS; a++)
                for (int b = 0; b < pmfp_pkg::MAX_INNER; b++) begin
                    li = (s * pmfp_pkg::MAX_ROWS + a) * pmfp_pkg::MAX_INNER + b;
                    ri = (s * pmfp_pkg::MAX_INNER + a) * pmfp_pkg::MAX_COLS + b;
                    if (s < r1_e * p_e && a < nr_e && b < ni_e && !lcorr_set[li])
                        push_item(pmfp_pkg::CMD_LOAD_LEFT_CORR, a, b, s, pick_value());
                    if (s < r2_e * p_e && a < ni_e && b < nc_e && !rcorr_set[ri])
                        push_item(pmfp_pkg::CMD_LOAD_RIGHT_CORR, a, b, s, pick_value());
                end
    endfunction

    // One random command: mostly reads into the active region, some loads and noise.
    function automatic void push_random();
        int pick = $urandom_range(0, 99);
        int row = $urandom_range(0, 1) ? $urandom_range(0, nr_e - 1) : $urandom_range(0, 7);
        int col = $urandom_range(0, 1) ? $urandom_range(0, nc_e - 1) : $urandom_range(0, 7);
        if (pick < 30) begin
            push_item(pmfp_pkg::CMD_READ_NODE, row, col,
                      $urandom_range(0, 9) ? $urandom_range(0, p_e) : $urandom_range(0, 511), 0);
        end else if (pick < 62) begin
            push_item(pmfp_pkg::CMD_READ_CORR, row, col,
                      $urandom_range(0, 9)
                          ? $urandom_range(0, 2 * pmfp_pkg::MAX_ORDER * p_e - 1)
                          : $urandom_range(0, 511), $urandom);
        end else if (pick < 86) begin
            // in-range reload of an operand element (node slices up to the mesh size)
            case ($urandom_range(0, 3))
                0: push_item(pmfp_pkg::CMD_LOAD_LEFT_NODE, $urandom_range(0, 7),
                             $urandom_range(0, 7), $urandom_range(0, p_e), pick_value());
                1: push_item(pmfp_pkg::CMD_LOAD_RIGHT_NODE, $urandom_range(0, 7),
                             $urandom_range(0, 7), $urandom_range(0, p_e), pick_value());
                2: push_item(pmfp_pkg::CMD_LOAD_LEFT_CORR, $urandom_range(0, 7),
                             $urandom_range(0, 7),
                             $urandom_range(0, pmfp_pkg::CORR_SLICES - 1), pick_value());
                default: push_item(pmfp_pkg::CMD_LOAD_RIGHT_CORR, $urandom_range(0, 7),
                                   $urandom_range(0, 7),
                                   $urandom_range(0, pmfp_pkg::CORR_SLICES - 1),
                                   pick_value());
            endcase
        end else if (pick < 94) begin
            // slice past the store: dropped
            push_item(3'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(pmfp_pkg::CORR_SLICES, 511), $urandom);
        end else begin
            push_item(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 511), $urandom);
        end
    endfunction

    // wait until the block has nothing left in flight
    task automatic settle();
        while (cmd_backlog.size() > 0 || cmd_if.valid || awaited.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [4:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_sizes(int rows, int inner, int cols, int mesh, int lord, int rord);
        reg_rows  = 4'(rows);
        reg_inner = 4'(inner);
        reg_cols  = 4'(cols);
        reg_mesh  = 7'(mesh);
        reg_lord  = 3'(lord);
        reg_rord  = 3'(rord);
        apb_write(5'(pmfp_pkg::REG_ROW_COUNT) << 2, 32'(reg_rows));
        apb_write(5'(pmfp_pkg::REG_INNER_COUNT) << 2, 32'(reg_inner));
        apb_write(5'(pmfp_pkg::REG_COLUMN_COUNT) << 2, 32'(reg_cols));
        apb_write(5'(pmfp_pkg::REG_MESH) << 2, 32'(reg_mesh));
        apb_write(5'(pmfp_pkg::REG_LEFT_ORDER) << 2, 32'(reg_lord));
        apb_write(5'(pmfp_pkg::REG_RIGHT_ORDER) << 2, 32'(reg_rord));
        refresh_sizes();
    endtask

    // One phase: configure, load operands, compute, random traffic, recompute, more traffic.
    task automatic run_phase(int rows, int inner, int cols, int mesh, int lord, int rord,
                             int n_rand);
        settle();
        n_phases++;
        set_sizes(rows, inner, cols, mesh, lord, rord);
        fill_operands();
        push_item(pmfp_pkg::CMD_COMPUTE, 0, 0, 0, 0);
        for (int n = 0; n < n_rand; n++) push_random();
        push_item(pmfp_pkg::CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 511), $urandom);
        for (int n = 0; n < n_rand; n++) push_random();
    endtask

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = '0;
        cmd_if.row_index = '0;
        cmd_if.col_index = '0;
        cmd_if.slice_index = '0;
        cmd_if.value = '0;
        res_if.ready = 1'b0;
        refresh_sizes();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // a write past the last register has no effect
        apb_write(ADDR_NO_REG, 32'hffffffff);

        // directed: small shape, dropped loads at every store, extreme values
        set_sizes(2, 3, 2, 3, 1, 1);
        n_phases++;
        push_item(pmfp_pkg::CMD_LOAD_LEFT_NODE, 7, 7, 511, 32'h7fffffff);
        push_item(pmfp_pkg::CMD_LOAD_LEFT_CORR, 7, 7, pmfp_pkg::CORR_SLICES, 32'h80000000);
        push_item(pmfp_pkg::CMD_LOAD_RIGHT_NODE, 7, 7, pmfp_pkg::NODE_SLICES, 32'hffffffff);
        push_item(pmfp_pkg::CMD_LOAD_RIGHT_CORR, 0, 0, 511, 32'h00000000);
        push_item(CMD_UNUSED, 7, 7, 511, 32'hffffffff);
        push_item(pmfp_pkg::CMD_LOAD_LEFT_NODE, 0, 0, 0, 32'h7fffffff);
        push_item(pmfp_pkg::CMD_LOAD_RIGHT_NODE, 0, 0, 0, 32'h7fffffff);
        push_item(pmfp_pkg::CMD_LOAD_LEFT_NODE, 1, 2, 1, 32'h80000000);
        push_item(pmfp_pkg::CMD_LOAD_RIGHT_NODE, 2, 1, 1, 32'h80000000);
        fill_operands();
        push_item(pmfp_pkg::CMD_COMPUTE, 0, 0, 0, 0);
        push_item(pmfp_pkg::CMD_READ_NODE, 0, 0, 0, 0);
        push_item(pmfp_pkg::CMD_READ_NODE, 1, 1, 1, 0);
        push_item(pmfp_pkg::CMD_READ_NODE, 7, 7, pmfp_pkg::MAX_MESH, 0);
        push_item(pmfp_pkg::CMD_READ_NODE, 0, 0, pmfp_pkg::NODE_SLICES, 0);
        push_item(pmfp_pkg::CMD_READ_NODE, 7, 7, 511, 32'hffffffff);
        push_item(pmfp_pkg::CMD_READ_CORR, 0, 0, 0, 0);
        push_item(pmfp_pkg::CMD_READ_CORR, 1, 1, 3, 0);
        push_item(pmfp_pkg::CMD_READ_CORR, 1, 0, 7, 0);
        push_item(pmfp_pkg::CMD_READ_CORR, 7, 7, 511, 0);
        for (int n = 0; n < 40; n++) push_random();

        // extremes of each register, one at a time where the cost allows
        run_phase(8, 8, 8, 1, 0, 0, 30);
        calm = 1'b1;                        // no gaps on either side here
        run_phase(1, 1, 1, 127, 0, 0, 40);
        calm = 1'b0;
        run_phase(0, 15, 0, 0, 7, 0, 30);
        run_phase(15, 2, 15, 2, 0, 7, 30);
        for (int ph = 0; ph < 3; ph++)
            run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(1, 6), $urandom_range(0, 3), $urandom_range(0, 3), 20);

        settle();
        $display("Covered %0d configurations: %0d computes, %0d reads, %0d loads.",
                 n_phases, n_computes, n_reads, n_loads);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d field mismatches", errors);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
